// ===== src/segment_frame_matrix_defines.svh =====
// ----------------------------------------------------------------------------
// segment frame matrix assertion macros
// shared concurrent assertion forms, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef SEGMENT_FRAME_MATRIX_DEFINES_SVH
`define SEGMENT_FRAME_MATRIX_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SFM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SFM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SFM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/sfm_pkg.sv =====
// ----------------------------------------------------------------------------
// sfm_pkg
// widths, payload types and fixed-point helpers of the segment frame matrix
// ----------------------------------------------------------------------------
package sfm_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned RadiusW     = 31;
  localparam int unsigned RadiusReset = 3277;
  localparam int unsigned MagW        = 31;
  localparam int unsigned SqW         = 2 * MagW;
  localparam int unsigned SumW        = 64;
  localparam int unsigned RootW       = SumW / 2;
  localparam int unsigned FracW       = 30;
  localparam int unsigned QuotW       = FracW + 1;
  localparam int unsigned NumW        = RootW + QuotW - 1;
  localparam int unsigned MinLen      = 7;
  localparam int unsigned Dot2Limit   = 2126008811;
  localparam int unsigned OneQ16      = 65536;

  typedef logic [2:0][DataW-1:0] vec3_t;

  typedef struct packed {
    logic signed [DataW-1:0] start_x;
    logic signed [DataW-1:0] start_y;
    logic signed [DataW-1:0] start_z;
    logic signed [DataW-1:0] end_x;
    logic signed [DataW-1:0] end_y;
    logic signed [DataW-1:0] end_z;
  } seg_t;

  typedef struct packed {
    logic signed [DataW-1:0] side_x;
    logic signed [DataW-1:0] side_y;
    logic signed [DataW-1:0] side_z;
    logic signed [DataW-1:0] axis_x;
    logic signed [DataW-1:0] axis_y;
    logic signed [DataW-1:0] axis_z;
    logic signed [DataW-1:0] normal_x;
    logic signed [DataW-1:0] normal_y;
    logic signed [DataW-1:0] normal_z;
    logic signed [DataW-1:0] mid_x;
    logic signed [DataW-1:0] mid_y;
    logic signed [DataW-1:0] mid_z;
  } frame_t;

  // round half away from zero, drop FracW fraction bits
  function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (FracW - 1))) >> FracW;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  // round half away from zero, drop one bit
  function automatic logic [DataW-1:0] rnd_half(input logic signed [33:0] v);
    logic [34:0] m;
    logic [34:0] r;
    logic [34:0] s;
    m = v[33] ? 35'(-v) : 35'(v);
    r = (m + 35'd1) >> 1;
    s = v[33] ? -r : r;
    return s[DataW-1:0];
  endfunction

  function automatic logic [DataW-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[DataW-1:0];
  endfunction

endpackage

// ===== src/sfm_seg_if.sv =====
// ----------------------------------------------------------------------------
// sfm_seg_if
// segment channel: valid, ready and the two endpoints
// ----------------------------------------------------------------------------
interface sfm_seg_if;
  logic          valid;
  logic          ready;
  sfm_pkg::seg_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/sfm_frame_if.sv =====
// ----------------------------------------------------------------------------
// sfm_frame_if
// frame channel: valid, ready and the transform columns
// ----------------------------------------------------------------------------
interface sfm_frame_if;
  logic            valid;
  logic            ready;
  sfm_pkg::frame_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/sfm_isqrt.sv =====
// ----------------------------------------------------------------------------
// sfm_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module sfm_isqrt #(
  parameter int unsigned TagW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [sfm_pkg::SumW-1:0]   rad_i,
  input  logic [TagW-1:0]            tag_i,
  output logic                       valid_o,
  output logic [sfm_pkg::RootW-1:0]  root_o,
  output logic [TagW-1:0]            tag_o
);

  localparam int unsigned W     = sfm_pkg::SumW;
  localparam int unsigned Steps = sfm_pkg::RootW;

  logic         vld_q [Steps];
  logic [W-1:0] rem_q [Steps];
  logic [W-1:0] res_q [Steps];
  logic [TagW-1:0] tag_q [Steps];

  for (genvar j = 0; j < Steps; j++) begin : g_stage
    localparam int unsigned K = Steps - 1 - j;
    logic            vld_in;
    logic [W-1:0]    rem_in;
    logic [W-1:0]    res_in;
    logic [TagW-1:0] tag_in;
    logic [W-1:0]    trial;
    logic [W-1:0]    rem_d;
    logic [W-1:0]    res_d;

    if (j == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = rad_i;
      assign res_in = '0;
      assign tag_in = tag_i;
    end else begin : g_rest
      assign vld_in = vld_q[j-1];
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
      assign tag_in = tag_q[j-1];
    end

    assign trial = res_in + (W'(1) << (2 * K));

    always_comb begin
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + (W'(1) << (2 * K));
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        res_q[j] <= res_d;
        tag_q[j] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign root_o  = res_q[Steps-1][sfm_pkg::RootW-1:0];
  assign tag_o   = tag_q[Steps-1];

endmodule

// ===== src/sfm_div.sv =====
// ----------------------------------------------------------------------------
// sfm_div
// pipelined restoring divider, three numerators over one divisor
// ----------------------------------------------------------------------------
module sfm_div #(
  parameter int unsigned TagW = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [sfm_pkg::RootW-1:0]            den_i,
  input  logic [2:0][sfm_pkg::NumW-1:0]        num_i,
  input  logic [TagW-1:0]                      tag_i,
  output logic                                 valid_o,
  output logic [2:0][sfm_pkg::QuotW-1:0]       quo_o,
  output logic [TagW-1:0]                      tag_o
);

  localparam int unsigned NW = sfm_pkg::NumW;
  localparam int unsigned QW = sfm_pkg::QuotW;
  localparam int unsigned DW = sfm_pkg::RootW;

  logic                 vld_q [QW];
  logic [2:0][NW-1:0]   rem_q [QW];
  logic [2:0][QW-1:0]   quo_q [QW];
  logic [DW-1:0]        den_q [QW];
  logic [TagW-1:0]      tag_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int unsigned P = QW - 1 - j;
    logic               vld_in;
    logic [2:0][NW-1:0] rem_in;
    logic [2:0][QW-1:0] quo_in;
    logic [DW-1:0]      den_in;
    logic [TagW-1:0]    tag_in;
    logic [NW-1:0]      dsh;
    logic [2:0][NW-1:0] rem_d;
    logic [2:0][QW-1:0] quo_d;

    if (j == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_rest
      assign vld_in = vld_q[j-1];
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
      assign tag_in = tag_q[j-1];
    end

    assign dsh = NW'(den_in) << P;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_d[l] = rem_in[l] - dsh;
          quo_d[l] = quo_in[l] | (QW'(1) << P);
        end else begin
          rem_d[l] = rem_in[l];
          quo_d[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
        den_q[j] <= den_in;
        tag_q[j] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

// ===== src/sfm_norm.sv =====
// ----------------------------------------------------------------------------
// sfm_norm
// pipelined 3d normalize: squares, sum, square root, rounded division
// ----------------------------------------------------------------------------
module sfm_norm #(
  parameter int unsigned TagW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  sfm_pkg::vec3_t              vec_i,
  input  logic [TagW-1:0]             tag_i,
  output logic                        valid_o,
  output sfm_pkg::vec3_t              unit_o,
  output logic [sfm_pkg::RootW-1:0]   root_o,
  output logic [TagW-1:0]             tag_o
);

  localparam int unsigned MW    = sfm_pkg::MagW;
  localparam int unsigned DW    = sfm_pkg::DataW;
  localparam int unsigned RW    = sfm_pkg::RootW;
  localparam int unsigned NW    = sfm_pkg::NumW;
  localparam int unsigned FW    = sfm_pkg::FracW;
  localparam int unsigned QW    = sfm_pkg::QuotW;
  localparam int unsigned SqrtW = 3 * MW + 3 + TagW;
  localparam int unsigned DivW  = 3 + RW + TagW;

  // stage 1: magnitudes
  logic                s1_valid_q;
  logic [2:0][MW-1:0]  s1_mag_q;
  logic [2:0]          s1_neg_q;
  logic [TagW-1:0]     s1_tag_q;
  logic [2:0][MW-1:0]  s1_mag_d;
  // stage 2: squares
  logic                s2_valid_q;
  logic [2:0][sfm_pkg::SqW-1:0] s2_sq_q;
  logic [2:0][MW-1:0]  s2_mag_q;
  logic [2:0]          s2_neg_q;
  logic [TagW-1:0]     s2_tag_q;
  // stage 3: sum of squares
  logic                s3_valid_q;
  logic [sfm_pkg::SumW-1:0] s3_sum_q;
  logic [2:0][MW-1:0]  s3_mag_q;
  logic [2:0]          s3_neg_q;
  logic [TagW-1:0]     s3_tag_q;
  // root
  logic                rt_valid;
  logic [RW-1:0]       rt_root;
  logic [SqrtW-1:0]    rt_tag;
  logic [2:0][MW-1:0]  rt_mag;
  logic [2:0]          rt_neg;
  logic [TagW-1:0]     rt_user;
  // numerator setup
  logic                p_valid_q;
  logic [2:0][NW-1:0]  p_num_q;
  logic [RW-1:0]       p_den_q;
  logic [2:0]          p_neg_q;
  logic [TagW-1:0]     p_tag_q;
  logic [2:0][NW-1:0]  p_num_d;
  // quotient
  logic [2:0][QW-1:0]  dv_quo;
  logic [DivW-1:0]     dv_tag;
  logic [2:0]          dv_neg;
  logic [RW-1:0]       dv_root;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_mag_d[i] = vec_i[i][DW-1] ? MW'(-$signed(vec_i[i])) : vec_i[i][MW-1:0];
      p_num_d[i]  = NW'({rt_mag[i], {FW{1'b0}}}) + NW'(rt_root[RW-1:1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      p_valid_q  <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      p_valid_q  <= rt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mag_q <= s1_mag_d;
      for (int i = 0; i < 3; i++) begin
        s1_neg_q[i] <= vec_i[i][DW-1];
        s2_sq_q[i]  <= s1_mag_q[i] * s1_mag_q[i];
      end
      s1_tag_q <= tag_i;
      s2_mag_q <= s1_mag_q;
      s2_neg_q <= s1_neg_q;
      s2_tag_q <= s1_tag_q;
      s3_sum_q <= sfm_pkg::SumW'(s2_sq_q[0]) + sfm_pkg::SumW'(s2_sq_q[1])
                + sfm_pkg::SumW'(s2_sq_q[2]);
      s3_mag_q <= s2_mag_q;
      s3_neg_q <= s2_neg_q;
      s3_tag_q <= s2_tag_q;
      p_num_q  <= p_num_d;
      p_den_q  <= rt_root;
      p_neg_q  <= rt_neg;
      p_tag_q  <= rt_user;
    end
  end

  sfm_isqrt #(.TagW(SqrtW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (s3_valid_q),
    .rad_i   (s3_sum_q),
    .tag_i   ({s3_mag_q, s3_neg_q, s3_tag_q}),
    .valid_o (rt_valid),
    .root_o  (rt_root),
    .tag_o   (rt_tag)
  );

  assign {rt_mag, rt_neg, rt_user} = rt_tag;

  sfm_div #(.TagW(DivW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (p_valid_q),
    .den_i   (p_den_q),
    .num_i   (p_num_q),
    .tag_i   ({p_neg_q, p_den_q, p_tag_q}),
    .valid_o (valid_o),
    .quo_o   (dv_quo),
    .tag_o   (dv_tag)
  );

  assign {dv_neg, dv_root, tag_o} = dv_tag;
  assign root_o = dv_root;

  // zero-length vector normalizes to zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_root == '0) begin
        unit_o[i] = '0;
      end else if (dv_neg[i]) begin
        unit_o[i] = DW'(-$signed({1'b0, dv_quo[i]}));
      end else begin
        unit_o[i] = DW'({1'b0, dv_quo[i]});
      end
    end
  end

endmodule

// ===== src/segment_frame_matrix.sv =====
// ----------------------------------------------------------------------------
// segment_frame_matrix
// transform columns that stretch a unit cylinder between two 3d endpoints
// ----------------------------------------------------------------------------
// Takes one segment (two Q16.16 endpoints) per cycle while the skid is
// empty and returns the side, axis and normal columns plus the midpoint of
// the placing transform. The pipeline is streaming: a new segment is
// accepted every cycle unless the skid holds a frame. It chains the three
// normalize units in series, each 67 stages deep (3 for magnitudes, squares
// and sum, 32 for the one-bit-per-stage square root, 1 for numerator setup,
// 31 for the one-bit-per-stage divider); the other 7 stages are delta,
// scaling, helper cross product, the two multiply and round steps and the
// output register. The whole pipeline advances together; an output register
// plus a one-entry skid lets the block keep taking segments while one
// finished frame waits on the sink. The tube radius register is written
// through cfg_we_i and should only change while no segment is in flight.
// ----------------------------------------------------------------------------
`include "segment_frame_matrix_defines.svh"

module segment_frame_matrix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfm_pkg::RadiusW-1:0]   cfg_wdata_i,
  sfm_seg_if.sink                       seg_i,
  sfm_frame_if.source                   frame_o
);

  localparam int unsigned DW    = sfm_pkg::DataW;
  localparam int unsigned RW    = sfm_pkg::RootW;
  localparam int unsigned Tag1W = 3 * DW + 1;
  localparam int unsigned Tag2W = 6 * DW + RW + 2;
  localparam int unsigned Tag3W = 9 * DW + 1;

  // tube radius register
  logic [sfm_pkg::RadiusW-1:0] radius_q;
  logic signed [DW-1:0]        radius_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= sfm_pkg::RadiusW'(sfm_pkg::RadiusReset);
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  assign radius_s = $signed({1'b0, radius_q});

  // pipeline advance: frozen only while the skid holds a frame
  logic adv;
  logic skid_valid_q;

  assign adv         = !skid_valid_q;
  assign seg_i.ready = adv;

  // ---------------------------------------------------------------- stage a1
  // segment delta (33 bit) and midpoint
  logic [2:0][DW-1:0] in_s, in_e;
  logic               a1_valid_q;
  logic [2:0][DW:0]   a1_d_q, a1_d_d;
  sfm_pkg::vec3_t     a1_mid_q, a1_mid_d;

  assign in_s = {seg_i.payload.start_z, seg_i.payload.start_y, seg_i.payload.start_x};
  assign in_e = {seg_i.payload.end_z, seg_i.payload.end_y, seg_i.payload.end_x};

  always_comb begin
    logic [DW:0] sum;
    for (int i = 0; i < 3; i++) begin
      a1_d_d[i] = $signed({in_e[i][DW-1], in_e[i]}) - $signed({in_s[i][DW-1], in_s[i]});
      sum       = $signed({in_e[i][DW-1], in_e[i]}) + $signed({in_s[i][DW-1], in_s[i]});
      // floor of half the sum
      a1_mid_d[i] = sum[DW:1];
    end
  end

  // ---------------------------------------------------------------- stage a2
  // halve all components when any delta needs 32 magnitude bits
  logic               a2_valid_q;
  sfm_pkg::vec3_t     a2_v_q, a2_v_d;
  logic               a2_sh_q, a2_sh_d;
  sfm_pkg::vec3_t     a2_mid_q;

  always_comb begin
    logic [2:0][DW:0] mag;
    logic [DW:0]      vm;
    for (int i = 0; i < 3; i++) begin
      mag[i] = a1_d_q[i][DW] ? (DW+1)'(-$signed(a1_d_q[i])) : a1_d_q[i];
    end
    a2_sh_d = mag[0][DW] | mag[0][DW-1] | mag[1][DW] | mag[1][DW-1]
            | mag[2][DW] | mag[2][DW-1];
    for (int i = 0; i < 3; i++) begin
      vm = a2_sh_d ? (mag[i] >> 1) : mag[i];
      a2_v_d[i] = a1_d_q[i][DW] ? DW'(-$signed({1'b0, vm[DW-2:0]}))
                                : DW'({1'b0, vm[DW-2:0]});
    end
  end

  // --------------------------------------------------------- direction unit
  logic               n1_valid;
  sfm_pkg::vec3_t     n1_dir;
  logic [RW-1:0]      n1_root;
  logic [Tag1W-1:0]   n1_tag;
  sfm_pkg::vec3_t     n1_mid;
  logic               n1_sh;

  sfm_norm #(.TagW(Tag1W)) u_norm_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (a2_valid_q),
    .vec_i   (a2_v_q),
    .tag_i   ({a2_mid_q, a2_sh_q}),
    .valid_o (n1_valid),
    .unit_o  (n1_dir),
    .root_o  (n1_root),
    .tag_o   (n1_tag)
  );

  assign {n1_mid, n1_sh} = n1_tag;

  // ----------------------------------------------------------------- stage b
  // length, short-segment flag, helper choice and helper x direction;
  // the helper is a constant so the cross product needs no multiplier
  logic               b_valid_q;
  sfm_pkg::vec3_t     b_c_q, b_c_d;
  sfm_pkg::vec3_t     b_dir_q;
  logic [RW-1:0]      b_root_q;
  logic               b_sh_q;
  logic               b_short_q, b_short_d;
  sfm_pkg::vec3_t     b_mid_q;

  always_comb begin
    logic [RW:0]        len;
    logic signed [33:0] dot2;
    logic [33:0]        dot_mag;
    logic               par;
    len       = n1_sh ? {n1_root, 1'b0} : {1'b0, n1_root};
    b_short_d = len < (RW+1)'(sfm_pkg::MinLen);
    dot2      = $signed({n1_dir[1][DW-1], n1_dir[1], 1'b0})
              + $signed({{2{n1_dir[2][DW-1]}}, n1_dir[2]});
    dot_mag   = dot2[33] ? 34'(-dot2) : 34'(dot2);
    par       = dot_mag > 34'(sfm_pkg::Dot2Limit);
    if (par) begin
      // helper (1,0,0)
      b_c_d[0] = '0;
      b_c_d[1] = DW'(-$signed(n1_dir[2]));
      b_c_d[2] = n1_dir[1];
    end else begin
      // helper (0,1,0.5)
      b_c_d[0] = sfm_pkg::rnd_half($signed({n1_dir[2][DW-1], n1_dir[2], 1'b0})
                 - $signed({{2{n1_dir[1][DW-1]}}, n1_dir[1]}));
      b_c_d[1] = sfm_pkg::rnd_half($signed({{2{n1_dir[0][DW-1]}}, n1_dir[0]}));
      b_c_d[2] = DW'(-$signed(n1_dir[0]));
    end
  end

  // --------------------------------------------------------------- right unit
  logic               n2_valid;
  sfm_pkg::vec3_t     n2_right;
  logic [Tag2W-1:0]   n2_tag;
  sfm_pkg::vec3_t     n2_dir;
  logic [RW-1:0]      n2_root;
  logic               n2_sh;
  logic               n2_short;
  sfm_pkg::vec3_t     n2_mid;

  sfm_norm #(.TagW(Tag2W)) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (b_valid_q),
    .vec_i   (b_c_q),
    .tag_i   ({b_dir_q, b_root_q, b_sh_q, b_short_q, b_mid_q}),
    .valid_o (n2_valid),
    .unit_o  (n2_right),
    .root_o  (),
    .tag_o   (n2_tag)
  );

  assign {n2_dir, n2_root, n2_sh, n2_short, n2_mid} = n2_tag;

  // ---------------------------------------------------------------- stage c1
  // cross product partials, side and axis products
  logic                    c1_valid_q;
  logic [5:0][63:0]        c1_x_q;
  logic [2:0][63:0]        c1_pr_q;
  logic [2:0][64:0]        c1_pa_q;
  logic                    c1_sh_q;
  logic                    c1_short_q;
  sfm_pkg::vec3_t          c1_mid_q;

  // ---------------------------------------------------------------- stage c2
  logic                    c2_valid_q;
  sfm_pkg::vec3_t          c2_c_q, c2_c_d;
  sfm_pkg::vec3_t          c2_side_q, c2_side_d;
  sfm_pkg::vec3_t          c2_axis_q, c2_axis_d;
  logic                    c2_short_q;
  sfm_pkg::vec3_t          c2_mid_q;

  always_comb begin
    logic signed [63:0] diff [3];
    logic [64:0]        pm;
    logic [64:0]        ps;
    logic [64:0]        r;
    diff[0] = $signed(c1_x_q[0]) - $signed(c1_x_q[1]);
    diff[1] = $signed(c1_x_q[2]) - $signed(c1_x_q[3]);
    diff[2] = $signed(c1_x_q[4]) - $signed(c1_x_q[5]);
    for (int i = 0; i < 3; i++) begin
      logic signed [63:0] cr;
      cr           = sfm_pkg::rnd_frac(diff[i]);
      c2_c_d[i]    = cr[DW-1:0];
      c2_side_d[i] = sfm_pkg::sat32(sfm_pkg::rnd_frac($signed(c1_pr_q[i])));
      // |dir| * len, rounded from Q30 * Q16.16 down to Q16.16 with the half
      pm = c1_pa_q[i][64] ? 65'(-$signed(c1_pa_q[i])) : c1_pa_q[i];
      ps = c1_sh_q ? (pm << 1) : pm;
      r  = (ps + (65'd1 << sfm_pkg::FracW)) >> (sfm_pkg::FracW + 1);
      c2_axis_d[i] = sfm_pkg::sat32(c1_pa_q[i][64] ? -$signed(r[63:0])
                                                  : $signed(r[63:0]));
    end
  end

  // ----------------------------------------------------------------- up unit
  logic               n3_valid;
  sfm_pkg::vec3_t     n3_up;
  logic [Tag3W-1:0]   n3_tag;
  sfm_pkg::vec3_t     n3_side;
  sfm_pkg::vec3_t     n3_axis;
  sfm_pkg::vec3_t     n3_mid;
  logic               n3_short;

  sfm_norm #(.TagW(Tag3W)) u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c2_valid_q),
    .vec_i   (c2_c_q),
    .tag_i   ({c2_side_q, c2_axis_q, c2_mid_q, c2_short_q}),
    .valid_o (n3_valid),
    .unit_o  (n3_up),
    .root_o  (),
    .tag_o   (n3_tag)
  );

  assign {n3_side, n3_axis, n3_mid, n3_short} = n3_tag;

  // ---------------------------------------------------------------- stage d1
  logic                d1_valid_q;
  logic [2:0][63:0]    d1_pn_q;
  sfm_pkg::vec3_t      d1_side_q;
  sfm_pkg::vec3_t      d1_axis_q;
  sfm_pkg::vec3_t      d1_mid_q;
  logic                d1_short_q;

  // pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_valid_q <= 1'b0;
      a2_valid_q <= 1'b0;
      b_valid_q  <= 1'b0;
      c1_valid_q <= 1'b0;
      c2_valid_q <= 1'b0;
      d1_valid_q <= 1'b0;
    end else if (adv) begin
      a1_valid_q <= seg_i.valid;
      a2_valid_q <= a1_valid_q;
      b_valid_q  <= n1_valid;
      c1_valid_q <= n2_valid;
      c2_valid_q <= c1_valid_q;
      d1_valid_q <= n3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_d_q     <= a1_d_d;
      a1_mid_q   <= a1_mid_d;
      a2_v_q     <= a2_v_d;
      a2_sh_q    <= a2_sh_d;
      a2_mid_q   <= a1_mid_q;
      b_c_q      <= b_c_d;
      b_dir_q    <= n1_dir;
      b_root_q   <= n1_root;
      b_sh_q     <= n1_sh;
      b_short_q  <= b_short_d;
      b_mid_q    <= n1_mid;
      // dir x right
      c1_x_q[0]  <= $signed(n2_dir[1]) * $signed(n2_right[2]);
      c1_x_q[1]  <= $signed(n2_dir[2]) * $signed(n2_right[1]);
      c1_x_q[2]  <= $signed(n2_dir[2]) * $signed(n2_right[0]);
      c1_x_q[3]  <= $signed(n2_dir[0]) * $signed(n2_right[2]);
      c1_x_q[4]  <= $signed(n2_dir[0]) * $signed(n2_right[1]);
      c1_x_q[5]  <= $signed(n2_dir[1]) * $signed(n2_right[0]);
      for (int i = 0; i < 3; i++) begin
        c1_pr_q[i] <= $signed(n2_right[i]) * radius_s;
        c1_pa_q[i] <= $signed(n2_dir[i]) * $signed({1'b0, n2_root});
        d1_pn_q[i] <= $signed(n3_up[i]) * radius_s;
      end
      c1_sh_q    <= n2_sh;
      c1_short_q <= n2_short;
      c1_mid_q   <= n2_mid;
      c2_c_q     <= c2_c_d;
      c2_side_q  <= c2_side_d;
      c2_axis_q  <= c2_axis_d;
      c2_short_q <= c1_short_q;
      c2_mid_q   <= c1_mid_q;
      d1_side_q  <= n3_side;
      d1_axis_q  <= n3_axis;
      d1_mid_q   <= n3_mid;
      d1_short_q <= n3_short;
    end
  end

  // ------------------------------------------------------------ frame build
  // short segment gives the identity columns and a zero midpoint
  logic            inc_valid;
  sfm_pkg::frame_t inc_frame;

  assign inc_valid = d1_valid_q & adv;

  always_comb begin
    sfm_pkg::vec3_t nrm;
    for (int i = 0; i < 3; i++) begin
      nrm[i] = sfm_pkg::sat32(sfm_pkg::rnd_frac($signed(d1_pn_q[i])));
    end
    if (d1_short_q) begin
      inc_frame = '0;
      inc_frame.side_x   = DW'(sfm_pkg::OneQ16);
      inc_frame.axis_y   = DW'(sfm_pkg::OneQ16);
      inc_frame.normal_z = DW'(sfm_pkg::OneQ16);
    end else begin
      inc_frame.side_x   = d1_side_q[0];
      inc_frame.side_y   = d1_side_q[1];
      inc_frame.side_z   = d1_side_q[2];
      inc_frame.axis_x   = d1_axis_q[0];
      inc_frame.axis_y   = d1_axis_q[1];
      inc_frame.axis_z   = d1_axis_q[2];
      inc_frame.normal_x = nrm[0];
      inc_frame.normal_y = nrm[1];
      inc_frame.normal_z = nrm[2];
      inc_frame.mid_x    = d1_mid_q[0];
      inc_frame.mid_y    = d1_mid_q[1];
      inc_frame.mid_z    = d1_mid_q[2];
    end
  end

  // ------------------------------------------------------ output and skid
  logic            out_valid_q, out_valid_d;
  sfm_pkg::frame_t out_q, out_d;
  logic            skid_valid_d;
  sfm_pkg::frame_t skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || frame_o.ready) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d  = inc_valid;
        out_d        = inc_frame;
      end
    end else if (inc_valid) begin
      // sink stalled: park the arriving frame
      skid_valid_d = 1'b1;
      skid_d       = inc_frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign frame_o.valid   = out_valid_q;
  assign frame_o.payload = out_q;

  // ------------------------------------------------------------- assertions
  `SFM_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q,
                  "skid full with empty output")
  `SFM_ASSERT_IMP(a_skid_fill_on_stall, clk_i, rst_ni, $rose(skid_valid_q),
                  $past(out_valid_q && !frame_o.ready), "skid filled without a stalled output")
  `SFM_ASSERT_NXT(a_skid_kept, clk_i, rst_ni, skid_valid_q && !frame_o.ready, skid_valid_q,
                  "parked frame dropped while stalled")

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// segment frame matrix testbench
// drives random and directed segments with random gaps, predicts each frame
// in fixed point and checks every accepted result in order
// ----------------------------------------------------------------------------
module testbench;

  // scoreboard: holds predicted frames in arrival order
  class frame_scoreboard;
    sfm_pkg::frame_t pending[$];
    int     errors;
    logic [sfm_pkg::RadiusW-1:0] radius;

    function new();
      errors = 0;
      radius = sfm_pkg::RadiusW'(sfm_pkg::RadiusReset);
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function longint rnd_shift(longint v, int sh);
      longint unsigned m;
      m = (mag(v) + (64'd1 << (sh - 1))) >> sh;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned normalize(longint v[3], output longint u[3]);
      longint unsigned m[3];
      longint unsigned sum;
      longint unsigned root;
      longint q;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = mag(v[i]);
        sum += m[i] * m[i];
      end
      root = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
        if (root == 0) begin
          u[i] = 0;
        end else begin
          q = longint'(((m[i] << 30) + (root >> 1)) / root);
          u[i] = v[i] < 0 ? -q : q;
        end
      end
      return root;
    endfunction

    function void cross_norm(longint a[3], longint b[3], output longint u[3]);
      longint c[3];
      c[0] = rnd_shift(a[1] * b[2] - a[2] * b[1], 30);
      c[1] = rnd_shift(a[2] * b[0] - a[0] * b[2], 30);
      c[2] = rnd_shift(a[0] * b[1] - a[1] * b[0], 30);
      void'(normalize(c, u));
    endfunction

    function sfm_pkg::frame_t frame_of(sfm_pkg::seg_t seg);
      longint s[3], e[3], d[3], v[3], dir[3], up[3], rgt[3], upn[3], res[12];
      longint unsigned root, len, m;
      longint t, dot2;
      int sh;
      sfm_pkg::frame_t f;
      s[0] = seg.start_x; s[1] = seg.start_y; s[2] = seg.start_z;
      e[0] = seg.end_x;   e[1] = seg.end_y;   e[2] = seg.end_z;
      sh = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = e[i] - s[i];
        if (mag(d[i]) >= (64'd1 << 31)) sh = 1;
      end
      for (int i = 0; i < 3; i++) begin
        t = longint'(mag(d[i]) >> sh);
        v[i] = d[i] < 0 ? -t : t;
      end
      root = normalize(v, dir);
      len = root << sh;
      // midpoint rounds toward minus infinity
      for (int i = 0; i < 3; i++) begin
        t = s[i] + e[i];
        res[9 + i] = t >= 0 ? t / 2 : -((-t + 1) / 2);
      end
      if (len < sfm_pkg::MinLen) begin
        // short segment: identity columns, zero center
        for (int i = 0; i < 12; i++) res[i] = 0;
        res[0] = sfm_pkg::OneQ16; res[4] = sfm_pkg::OneQ16; res[8] = sfm_pkg::OneQ16;
      end else begin
        dot2 = 2 * dir[1] + dir[2];
        if (mag(dot2) > sfm_pkg::Dot2Limit) begin
          up[0] = 64'd1 << 30; up[1] = 0; up[2] = 0;
        end else begin
          up[0] = 0; up[1] = 64'd1 << 30; up[2] = 64'd1 << 29;
        end
        cross_norm(up, dir, rgt);
        cross_norm(dir, rgt, upn);
        for (int i = 0; i < 3; i++) begin
          m = (mag(dir[i]) * len + (64'd1 << 30)) >> 31;
          res[i] = clamp32(rnd_shift(rgt[i] * longint'(radius), 30));
          res[3 + i] = clamp32(dir[i] < 0 ? -longint'(m) : longint'(m));
          res[6 + i] = clamp32(rnd_shift(upn[i] * longint'(radius), 30));
        end
      end
      f = {res[0][31:0], res[1][31:0], res[2][31:0], res[3][31:0], res[4][31:0],
           res[5][31:0], res[6][31:0], res[7][31:0], res[8][31:0], res[9][31:0],
           res[10][31:0], res[11][31:0]};
      return f;
    endfunction

    function void note_segment(sfm_pkg::seg_t seg);
      pending = {pending, frame_of(seg)};
    endfunction

    function void check_frame(sfm_pkg::frame_t got);
      sfm_pkg::frame_t want;
      logic [11:0][31:0] w, g;
      if (pending.size() == 0) begin
        $display("%0t unexpected frame %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      w = want;
      g = got;
      for (int i = 11; i >= 0; i--) begin
        if (w[i] !== g[i]) begin
          $display("%0t field %0d expected %h actual %h", $realtime, 11 - i, w[i], g[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [sfm_pkg::RadiusW-1:0] cfg_wdata_i = '0;

  sfm_seg_if   seg_ch();
  sfm_frame_if frame_ch();

  frame_scoreboard board = new();
  int  stall_long = 0;   // cycles of forced hold-off on the result side

  segment_frame_matrix DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .seg_i(seg_ch.sink),
    .frame_o(frame_ch.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    seg_ch.valid = 0;
    seg_ch.payload = '0;
    frame_ch.ready = 0;
  end

  // result side: random waits per transfer, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (frame_ch.valid && frame_ch.ready) board.check_frame(frame_ch.payload);
  end

  initial begin
    int waitn;
    @(posedge rst_ni);
    forever begin
      if (stall_long > 0) begin
        frame_ch.ready <= 0;
        repeat (stall_long) @(posedge clk_i);
        stall_long = 0;
      end
      waitn = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 4) == 0) waitn = 0;
      if (waitn > 0) begin
        frame_ch.ready <= 0;
        repeat (waitn) @(posedge clk_i);
      end
      frame_ch.ready <= 1;
      @(posedge clk_i);
      while (!frame_ch.valid) @(posedge clk_i);
    end
  end

  // offer one segment and wait for its transfer
  task automatic send_segment(sfm_pkg::seg_t seg, bit no_gap);
    int waitn;
    waitn = no_gap ? 0 : $urandom_range(0, 16);
    if (waitn > 0) begin
      seg_ch.valid <= 0;
      repeat (waitn) @(posedge clk_i);
    end
    seg_ch.valid <= 1;
    seg_ch.payload <= seg;
    @(posedge clk_i);
    while (!seg_ch.ready) @(posedge clk_i);
    board.note_segment(seg);
  endtask

  task automatic write_radius(logic [sfm_pkg::RadiusW-1:0] r);
    cfg_we_i <= 1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 0;
    board.radius = r;
  endtask

  // let the pipe empty before touching the radius
  task automatic drain();
    seg_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8)) - 4);
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic sfm_pkg::seg_t rand_segment();
    sfm_pkg::seg_t s;
    s.start_x = rand_coord(); s.start_y = rand_coord(); s.start_z = rand_coord();
    case ($urandom_range(0, 4))
      0: begin
        // short or zero segment
        s.end_x = s.start_x + 32'($signed($urandom_range(0, 6)) - 3);
        s.end_y = s.start_y + 32'($signed($urandom_range(0, 6)) - 3);
        s.end_z = s.start_z + 32'($signed($urandom_range(0, 6)) - 3);
      end
      1: begin
        // near the helper direction (0,1,0.5)
        s.end_x = s.start_x + 32'($signed($urandom_range(0, 200)) - 100);
        s.end_y = s.start_y + 32'd2000000;
        s.end_z = s.start_z + 32'd1000000 + 32'($signed($urandom_range(0, 200)) - 100);
      end
      default: begin
        s.end_x = rand_coord(); s.end_y = rand_coord(); s.end_z = rand_coord();
      end
    endcase
    return s;
  endfunction

  function automatic sfm_pkg::seg_t mk(int sx, int sy, int sz, int ex, int ey, int ez);
    sfm_pkg::seg_t s;
    s = {sx, sy, sz, ex, ey, ez};
    return s;
  endfunction

  initial begin
    logic [sfm_pkg::RadiusW-1:0] radii[5];
    int count;
    radii = '{31'd0, 31'h7fff_ffff, 31'd65536, 31'd1, 31'd3277};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, short segments, parallel switch, degenerate cases
    send_segment(mk(0, 0, 0, 0, 0, 0), 0);
    send_segment(mk(0, 0, 0, 6, 0, 0), 0);
    send_segment(mk(0, 0, 0, 7, 0, 0), 0);
    send_segment(mk(0, 0, 0, 0, 65536, 0), 0);
    send_segment(mk(0, 0, 0, 0, 0, 65536), 0);
    send_segment(mk(0, 0, 0, 0, 131072, 65536), 0);
    send_segment(mk(0, 0, 0, 0, -131072, -65536), 0);
    send_segment(mk(-2147483648, -2147483648, -2147483648,
                    2147483647, 2147483647, 2147483647), 0);
    send_segment(mk(2147483647, 2147483647, 2147483647,
                    -2147483648, -2147483648, -2147483648), 0);
    send_segment(mk(2147483647, 0, 0, -2147483648, 0, 0), 1);
    send_segment(mk(-1, -1, -1, -2, -2, -2), 1);
    send_segment(mk(-3, 5, -7, 3, -5, 7), 1);
    send_segment(mk(2147483647, 2147483647, 2147483647,
                    2147483647, 2147483647, 2147483647), 0);
    send_segment(mk(-2147483648, 0, 2147483647, 0, -2147483648, 0), 0);
    send_segment(mk(0, 0, 0, 65536, 0, 0), 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_radius(radii[ph]);
      // the hold-off phase runs long enough for frames to back up to the input
      count = (ph == 2) ? 260 : 95;
      for (int n = 0; n < count; n++) begin
        // one long receiver hold-off while segments keep coming back to back
        if (ph == 2 && n == 10) stall_long = 400;
        send_segment(rand_segment(), (ph == 2 && n < 250) || $urandom_range(0, 3) == 0);
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/sfm_pkg.sv
src/sfm_seg_if.sv
src/sfm_frame_if.sv
src/sfm_isqrt.sv
src/sfm_div.sv
src/sfm_norm.sv
src/segment_frame_matrix.sv
sim/testbench.sv
